[rtl/core/fpcu_pkg.sv]
// Shared types, constants and tables for the first-person camera update block.
package fpcu_pkg;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam longint HALF_PI_Q30    = 64'sd1686629713;
    localparam longint QUARTER_PI_Q30 = 64'sd843314857;

    typedef logic [3:0] t_term;
    // sin series uses terms 0..4, cos series terms 5..10
    localparam t_term SIN_LAST = 4'd4;
    localparam t_term SC_LAST  = 4'd10;

    typedef enum logic [1:0] {
        MUL_Q30,    // rounded, >> 30
        MUL_QA,     // rounded, >> angle fraction bits
        MUL_RAW,    // full product
        MUL_RECIP   // floor, >> 32 (reciprocal estimate)
    } t_mul_mode;

    function automatic logic [7:0] sc_den(input t_term idx);
        logic [7:0] d;
        unique case (idx)
            4'd0:    d = 8'd110;
            4'd1:    d = 8'd72;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd20;
            4'd4:    d = 8'd6;
            4'd5:    d = 8'd132;
            4'd6:    d = 8'd90;
            4'd7:    d = 8'd56;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / sc_den(idx))
    function automatic logic [31:0] sc_recip(input t_term idx);
        logic [31:0] r;
        unique case (idx)
            4'd0:    r = 32'd39045157;
            4'd1:    r = 32'd59652323;
            4'd2:    r = 32'd102261126;
            4'd3:    r = 32'd214748364;
            4'd4:    r = 32'd715827882;
            4'd5:    r = 32'd32537631;
            4'd6:    r = 32'd47721858;
            4'd7:    r = 32'd76695844;
            4'd8:    r = 32'd143165576;
            4'd9:    r = 32'd357913941;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] s;
        if (v > 64'sd2147483647) begin
            s = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

endpackage

[rtl/core/first_person_camera_update.sv]
// First-person camera update: position, look-at point and pitch sum, one command per request.
//
// Input channel: i_in_valid / o_in_stall carry one request (cmd, yaw, pitch, speed).
// A request is taken when valid is high and stall is low. The block takes one
// request at a time and holds o_in_stall high until its result sits in the
// output register.
// Output channel: o_out_valid / i_out_stall carry the full state after each
// request. The result register holds while the receiver stalls; a new request
// is accepted meanwhile, and its result waits until the register frees up.
// A move takes two products; the unused command goes straight to the result.
// A look adds quadrant reduction steps for both turns and may skip the pitch
// turn.
// A look is dominated by one shared 33x18 multiplier (40 products plus 22
// reciprocal products for the two sin/cos series), a 32-step square root and
// two 31-step long divisions.
// Configuration: i_cfg_we writes pitch_limit; write only while idle.
// Reset (synchronous, active low): position (0, 5.0), look-at point at the
// origin, pitch sum zero, limit 1.5 rad, no result pending.
module first_person_camera_update #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [13:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [15:0] i_yaw_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_speed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_look_x,
    output logic signed [31:0] o_look_y,
    output logic signed [31:0] o_look_z,
    output logic signed [14:0] o_pitch_total
);
    import fpcu_pkg::*;

    localparam int ANG_SH = 30 - ANGLE_FRAC_BITS;
    localparam int TH_W   = 18;
    localparam int T_W    = TH_W + ANG_SH + 1;
    localparam logic signed [31:0] POS_Z_RST = 32'(64'd5 << COORD_FRAC_BITS);
    localparam logic [14:0] LIM_RST = 15'(3 << (ANGLE_FRAC_BITS - 1));
    localparam logic signed [T_W-1:0] K_HP     = T_W'(HALF_PI_Q30);
    localparam logic signed [T_W-1:0] K_QPI    = T_W'(QUARTER_PI_Q30);
    localparam logic signed [T_W-1:0] K_QPI_M1 = T_W'(QUARTER_PI_Q30 - 1);

    typedef enum logic [5:0] {
        S_IDLE, S_DECODE, S_MV1, S_MV2,
        S_PT0, S_PT1, S_PT2, S_SQRT, S_DVX0, S_DIV, S_DVX1, S_DVZ1,
        S_SC0, S_SCK, S_SC1, S_SC2, S_SC3, S_SC4,
        S_PM0, S_PM1, S_PM2, S_PM3, S_PM4, S_PM5, S_PM6, S_PM7, S_PM8,
        S_YAW0, S_YW0, S_YW1, S_YW2, S_YW3, S_YW4,
        S_MUL0, S_MUL1, S_MUL2, S_DONE
    } t_state;

    t_state r_state, r_mret, r_dv_ret, r_sc_ret;

    // architectural state
    logic signed [31:0] r_px, r_pz, r_tx, r_ty, r_tz;
    logic signed [15:0] r_psum;
    logic [14:0]        r_limit;

    // request
    logic [1:0]         r_cmd;
    logic signed [15:0] r_yaw, r_pitch, r_speed;

    // working registers
    logic signed [33:0] r_dx, r_dz;
    logic signed [TH_W-1:0] r_theta;
    logic [30:0]        r_a, r_b;
    logic               r_sh;
    logic [62:0]        r_q, r_sq_rem, r_sq_res, r_sq_bit;
    logic [60:0]        r_dv_rem;
    logic [61:0]        r_dv_den;
    logic [30:0]        r_dv_q;
    logic [4:0]         r_dv_cnt;
    logic [31:0]        r_m1;
    logic [32:0]        r_m;
    logic signed [31:0] r_rx, r_rz;
    logic signed [T_W-1:0] r_r;
    logic [1:0]         r_k;
    logic signed [31:0] r_x2, r_ts, r_tc, r_s, r_c;
    t_term              r_term;
    logic               r_p_neg;
    logic [31:0]        r_p_mag;
    logic signed [63:0] r_t1, r_t2, r_nx, r_nz, r_ddx;

    // shared multiplier
    logic signed [32:0] r_ma;
    logic signed [34:0] r_mb;
    t_mul_mode          r_mmode;
    logic [67:0]        r_macc;
    logic signed [63:0] r_prod;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_out_px, r_out_pz, r_out_tx, r_out_ty, r_out_tz;
    logic signed [14:0] r_out_pt;

    // multiplier datapath
    logic               m_neg;
    logic [32:0]        m_amag;
    logic [34:0]        m_bmag;
    logic [17:0]        m_half;
    logic [50:0]        m_pp;
    logic [67:0]        m_rnd;
    logic signed [63:0] m_res;

    always_comb begin
        m_neg  = r_ma[32] ^ r_mb[34];
        m_amag = r_ma[32] ? 33'(-r_ma) : 33'(r_ma);
        m_bmag = r_mb[34] ? 35'(-r_mb) : 35'(r_mb);
        m_half = (r_state == S_MUL1) ? {1'b0, m_bmag[34:18]} : m_bmag[17:0];
        m_pp   = 51'(m_amag) * 51'(m_half);
        unique case (r_mmode)
            MUL_Q30:   m_rnd = (r_macc + (68'(1) << 29)) >> 30;
            MUL_QA:    m_rnd = (r_macc + (68'(1) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
            MUL_RAW:   m_rnd = r_macc;
            default:   m_rnd = r_macc >> 32;
        endcase
        m_res = m_neg ? -signed'(m_rnd[63:0]) : signed'(m_rnd[63:0]);
    end

    // pitch clamp
    logic signed [TH_W-1:0] pc_lim, pc_last, pc_sum, pc_new, pc_theta;
    logic                   pc_do;
    always_comb begin
        pc_lim  = signed'(TH_W'(r_limit));
        pc_last = TH_W'(r_psum);
        pc_sum  = pc_last + TH_W'(r_pitch);
        if (pc_sum > pc_lim) begin
            pc_new   = pc_lim;
            pc_theta = pc_lim - pc_last;
            pc_do    = (pc_last != pc_lim);
        end else if (pc_sum < -pc_lim) begin
            pc_new   = -pc_lim;
            pc_theta = -pc_lim - pc_last;
            pc_do    = (pc_last != -pc_lim);
        end else begin
            pc_new   = pc_sum;
            pc_theta = TH_W'(r_pitch);
            pc_do    = 1'b1;
        end
    end

    // horizontal axis magnitudes, halved when too long
    logic [32:0] pt_ua, pt_ub;
    logic        pt_sh;
    logic [30:0] pt_a, pt_b;
    logic [62:0] pt_q;
    always_comb begin
        pt_ua = r_dx[33] ? 33'(-r_dx) : 33'(r_dx);
        pt_ub = r_dz[33] ? 33'(-r_dz) : 33'(r_dz);
        pt_sh = (|pt_ua[32:31]) | (|pt_ub[32:31]);
        pt_a  = pt_sh ? pt_ua[31:1] : pt_ua[30:0];
        pt_b  = pt_sh ? pt_ub[31:1] : pt_ub[30:0];
        pt_q  = r_q + r_prod[62:0];
    end

    // square root step
    logic [62:0] sq_sum;
    logic        sq_ge;
    assign sq_sum = r_sq_res + r_sq_bit;
    assign sq_ge  = (r_sq_rem >= sq_sum);

    // long division step
    logic               dv_ge;
    logic signed [31:0] dv_qs;
    assign dv_ge = ({1'b0, r_dv_rem} >= r_dv_den);
    assign dv_qs = signed'({1'b0, r_dv_q});

    // series term: divide by a small constant through its reciprocal
    logic [7:0]         sc_d;
    logic [31:0]        sc_qe, sc_q;
    logic [39:0]        sc_rem;
    logic signed [31:0] sc_nv, sc_sv;
    always_comb begin
        sc_d   = sc_den(r_term);
        sc_qe  = r_prod[31:0];
        sc_rem = 40'(r_p_mag) - 40'(sc_qe) * 40'(sc_d);
        sc_q   = sc_qe + 32'(sc_rem >= 40'(sc_d));
        sc_nv  = ONE_Q30 - (r_p_neg ? -signed'(sc_q) : signed'(sc_q));
        sc_sv  = r_prod[31:0];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_px;
    assign o_pos_z       = r_out_pz;
    assign o_look_x      = r_out_tx;
    assign o_look_y      = r_out_ty;
    assign o_look_z      = r_out_tz;
    assign o_pitch_total = r_out_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_px        <= '0;
            r_pz        <= POS_Z_RST;
            r_tx        <= '0;
            r_ty        <= '0;
            r_tz        <= '0;
            r_psum      <= '0;
            r_limit     <= LIM_RST;
        end else begin
            if (i_cfg_we) begin
                r_limit <= {1'b0, i_cfg_data};
            end
            // the done state reloads the register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_cmd;
                        r_yaw   <= i_yaw_angle;
                        r_pitch <= i_pitch_angle;
                        r_speed <= i_speed;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_dx <= 34'(r_tx) - 34'(r_px);
                    r_dz <= 34'(r_tz) - 34'(r_pz);
                    priority case (r_cmd)
                        2'd0: begin
                            r_psum  <= 16'(pc_new);
                            r_theta <= pc_theta;
                            r_state <= pc_do ? S_PT0 : S_YAW0;
                        end
                        2'd1: begin
                            r_ma    <= 33'(r_speed);
                            r_mb    <= 35'(34'(r_tx) - 34'(r_px));
                            r_mmode <= MUL_QA;
                            r_mret  <= S_MV1;
                            r_state <= S_MUL0;
                        end
                        2'd2: begin
                            r_ma    <= 33'(r_speed);
                            r_mb    <= 35'(34'(r_tz) - 34'(r_pz));
                            r_mmode <= MUL_QA;
                            r_mret  <= S_MV1;
                            r_state <= S_MUL0;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MV1: begin
                    r_ddx   <= r_prod;
                    r_ma    <= 33'(r_speed);
                    r_mb    <= (r_cmd == 2'd1) ? 35'(r_dz) : -35'(r_dx);
                    r_mmode <= MUL_QA;
                    r_mret  <= S_MV2;
                    r_state <= S_MUL0;
                end
                S_MV2: begin
                    r_px    <= sat32(64'(r_px) + r_ddx);
                    r_pz    <= sat32(64'(r_pz) + r_prod);
                    r_tx    <= sat32(64'(r_tx) + r_ddx);
                    r_tz    <= sat32(64'(r_tz) + r_prod);
                    r_state <= S_DONE;
                end

                // pitch turn about the horizontal axis
                S_PT0: begin
                    r_a     <= pt_a;
                    r_b     <= pt_b;
                    r_sh    <= pt_sh;
                    r_ma    <= signed'(33'(pt_a));
                    r_mb    <= signed'(35'(pt_a));
                    r_mmode <= MUL_RAW;
                    r_mret  <= S_PT1;
                    r_state <= S_MUL0;
                end
                S_PT1: begin
                    r_q     <= r_prod[62:0];
                    r_ma    <= signed'(33'(r_b));
                    r_mb    <= signed'(35'(r_b));
                    r_mmode <= MUL_RAW;
                    r_mret  <= S_PT2;
                    r_state <= S_MUL0;
                end
                S_PT2: begin
                    if (pt_q == '0) begin
                        r_state <= S_YAW0;
                    end else begin
                        r_sq_rem <= pt_q;
                        r_sq_res <= '0;
                        r_sq_bit <= 63'(1) << 62;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_sq_rem <= r_sq_rem - sq_sum;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    if (r_sq_bit[0]) begin
                        r_state <= S_DVX0;
                    end
                end
                S_DVX0: begin
                    r_m1     <= r_sq_res[31:0];
                    r_dv_rem <= {r_a, 30'd0};
                    r_dv_den <= {r_sq_res[31:0], 30'd0};
                    r_dv_q   <= '0;
                    r_dv_cnt <= 5'd30;
                    r_dv_ret <= S_DVX1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (dv_ge) begin
                        r_dv_rem <= r_dv_rem - r_dv_den[60:0];
                    end
                    r_dv_q   <= {r_dv_q[29:0], dv_ge};
                    r_dv_den <= r_dv_den >> 1;
                    r_dv_cnt <= r_dv_cnt - 5'd1;
                    if (r_dv_cnt == '0) begin
                        r_state <= r_dv_ret;
                    end
                end
                S_DVX1: begin
                    r_rx     <= r_dx[33] ? -dv_qs : dv_qs;
                    r_dv_rem <= {r_b, 30'd0};
                    r_dv_den <= {r_m1, 30'd0};
                    r_dv_q   <= '0;
                    r_dv_cnt <= 5'd30;
                    r_dv_ret <= S_DVZ1;
                    r_state  <= S_DIV;
                end
                S_DVZ1: begin
                    r_rz     <= r_dz[33] ? -dv_qs : dv_qs;
                    r_m      <= r_sh ? {r_m1, 1'b0} : {1'b0, r_m1};
                    r_sc_ret <= S_PM0;
                    r_state  <= S_SC0;
                end

                // sin/cos of r_theta
                S_SC0: begin
                    r_r     <= T_W'(r_theta) <<< ANG_SH;
                    r_k     <= '0;
                    r_state <= S_SCK;
                end
                S_SCK: begin
                    priority if (r_r >= K_QPI_M1) begin
                        r_r <= r_r - K_HP;
                        r_k <= r_k + 2'd1;
                    end else if (r_r < -K_QPI) begin
                        r_r <= r_r + K_HP;
                        r_k <= r_k - 2'd1;
                    end else begin
                        r_ma    <= 33'(r_r);
                        r_mb    <= 35'(r_r);
                        r_mmode <= MUL_Q30;
                        r_mret  <= S_SC1;
                        r_state <= S_MUL0;
                    end
                end
                S_SC1: begin
                    r_x2    <= r_prod[31:0];
                    r_ts    <= ONE_Q30;
                    r_tc    <= ONE_Q30;
                    r_term  <= '0;
                    r_ma    <= 33'(signed'(r_prod[31:0]));
                    r_mb    <= 35'(ONE_Q30);
                    r_mmode <= MUL_Q30;
                    r_mret  <= S_SC2;
                    r_state <= S_MUL0;
                end
                S_SC2: begin
                    r_p_neg <= r_prod[63];
                    r_p_mag <= r_prod[63] ? 32'(-r_prod) : r_prod[31:0];
                    r_ma    <= signed'({1'b0, (r_prod[63] ? 32'(-r_prod) : r_prod[31:0])});
                    r_mb    <= signed'(35'(sc_recip(r_term)));
                    r_mmode <= MUL_RECIP;
                    r_mret  <= S_SC3;
                    r_state <= S_MUL0;
                end
                S_SC3: begin
                    if (r_term <= SIN_LAST) begin
                        r_ts <= sc_nv;
                    end else begin
                        r_tc <= sc_nv;
                    end
                    r_mmode <= MUL_Q30;
                    r_state <= S_MUL0;
                    if (r_term == SC_LAST) begin
                        r_ma   <= 33'(r_r);
                        r_mb   <= 35'(r_ts);
                        r_mret <= S_SC4;
                    end else begin
                        r_term <= r_term + 4'd1;
                        r_ma   <= 33'(r_x2);
                        r_mb   <= (r_term == SIN_LAST) ? 35'(r_tc) : 35'(sc_nv);
                        r_mret <= S_SC2;
                    end
                end
                S_SC4: begin
                    unique case (r_k)
                        2'd0: begin r_s <= sc_sv;  r_c <= r_tc;  end
                        2'd1: begin r_s <= r_tc;   r_c <= -sc_sv; end
                        2'd2: begin r_s <= -sc_sv; r_c <= -r_tc; end
                        default: begin r_s <= -r_tc; r_c <= sc_sv; end
                    endcase
                    r_state <= r_sc_ret;
                end

                // pitch products
                S_PM0: begin
                    r_ma <= 33'(r_rx); r_mb <= 35'(r_ty);
                    r_mmode <= MUL_Q30; r_mret <= S_PM1; r_state <= S_MUL0;
                end
                S_PM1: begin
                    r_ma <= 33'(r_s); r_mb <= 35'(r_prod);
                    r_mmode <= MUL_Q30; r_mret <= S_PM2; r_state <= S_MUL0;
                end
                S_PM2: begin
                    r_t2 <= r_prod;
                    r_ma <= 33'(r_c); r_mb <= 35'(r_dx);
                    r_mmode <= MUL_Q30; r_mret <= S_PM3; r_state <= S_MUL0;
                end
                S_PM3: begin
                    r_nx <= r_prod - r_t2;
                    r_ma <= 33'(r_rz); r_mb <= 35'(r_ty);
                    r_mmode <= MUL_Q30; r_mret <= S_PM4; r_state <= S_MUL0;
                end
                S_PM4: begin
                    r_ma <= 33'(r_s); r_mb <= 35'(r_prod);
                    r_mmode <= MUL_Q30; r_mret <= S_PM5; r_state <= S_MUL0;
                end
                S_PM5: begin
                    r_t2 <= r_prod;
                    r_ma <= 33'(r_c); r_mb <= 35'(r_dz);
                    r_mmode <= MUL_Q30; r_mret <= S_PM6; r_state <= S_MUL0;
                end
                S_PM6: begin
                    r_nz <= r_prod - r_t2;
                    r_ma <= 33'(r_c); r_mb <= 35'(r_ty);
                    r_mmode <= MUL_Q30; r_mret <= S_PM7; r_state <= S_MUL0;
                end
                S_PM7: begin
                    r_t1 <= r_prod;
                    r_ma <= 33'(r_s); r_mb <= signed'({2'b00, r_m});
                    r_mmode <= MUL_Q30; r_mret <= S_PM8; r_state <= S_MUL0;
                end
                S_PM8: begin
                    r_tx    <= sat32(64'(r_px) + r_nx);
                    r_ty    <= sat32(r_t1 + r_prod);
                    r_tz    <= sat32(64'(r_pz) + r_nz);
                    r_state <= S_YAW0;
                end

                // yaw turn about y
                S_YAW0: begin
                    r_dx     <= 34'(r_tx) - 34'(r_px);
                    r_dz     <= 34'(r_tz) - 34'(r_pz);
                    r_theta  <= TH_W'(r_yaw);
                    r_sc_ret <= S_YW0;
                    r_state  <= S_SC0;
                end
                S_YW0: begin
                    r_ma <= 33'(r_c); r_mb <= 35'(r_dx);
                    r_mmode <= MUL_Q30; r_mret <= S_YW1; r_state <= S_MUL0;
                end
                S_YW1: begin
                    r_t1 <= r_prod;
                    r_ma <= 33'(r_s); r_mb <= 35'(r_dz);
                    r_mmode <= MUL_Q30; r_mret <= S_YW2; r_state <= S_MUL0;
                end
                S_YW2: begin
                    r_t1 <= r_t1 + r_prod;
                    r_ma <= 33'(r_c); r_mb <= 35'(r_dz);
                    r_mmode <= MUL_Q30; r_mret <= S_YW3; r_state <= S_MUL0;
                end
                S_YW3: begin
                    r_t2 <= r_prod;
                    r_ma <= 33'(r_s); r_mb <= 35'(r_dx);
                    r_mmode <= MUL_Q30; r_mret <= S_YW4; r_state <= S_MUL0;
                end
                S_YW4: begin
                    r_tx    <= sat32(64'(r_px) + r_t1);
                    r_tz    <= sat32(64'(r_pz) + r_t2 - r_prod);
                    r_state <= S_DONE;
                end

                // shared multiplier: low half, high half, round and sign
                S_MUL0: begin
                    r_macc  <= 68'(m_pp);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_macc  <= r_macc + (68'(m_pp) << 18);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= m_res;
                    r_state <= r_mret;
                end

                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_px    <= r_px;
                        r_out_pz    <= r_pz;
                        r_out_tx    <= r_tx;
                        r_out_ty    <= r_ty;
                        r_out_tz    <= r_tz;
                        r_out_pt    <= r_psum[14:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted request did not start decode");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_sq_bit))
        else $error("square root bit lost");

    a_recip_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC3) |-> (sc_rem < 40'(2 * sc_d)))
        else $error("reciprocal quotient estimate off by more than one");
`endif

endmodule

[bench/tb_first_person_camera_update.sv]
// Self-checking bench for the first-person camera update block.
class camera_state_model;

    typedef struct {
        longint px, pz, lx, ly, lz, pt;
    } t_view;

    longint pos_x, pos_z, tgt_x, tgt_y, tgt_z, pitch_sum, pitch_lim;
    t_view  expected_views[$];
    int     errors;
    int     views_checked;

    function new();
        pos_x = 0;
        pos_z = longint'(5) << 16;
        tgt_x = 0;
        tgt_y = 0;
        tgt_z = 0;
        pitch_sum = 0;
        pitch_lim = 3 << 12;
        errors = 0;
        views_checked = 0;
    endfunction

    function void set_limit(logic [13:0] v);
        pitch_lim = v;
    endfunction

    function int pending();
        return expected_views.size();
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned magn(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // product shifted right, rounded half away from zero
    function longint mul_round(longint a, longint b, int sh);
        longint unsigned p;
        p = magn(a) * magn(b);
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned q);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > q) bit_w >>= 2;
        while (bit_w != 0) begin
            if (q >= res + bit_w) begin
                q -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function void sin_cos(longint theta, output longint sn, output longint cs);
        longint sden[5];
        longint cden[6];
        longint t, u, k, r, x2, ts, tc, s;
        sden = '{110, 72, 42, 20, 6};
        cden = '{132, 90, 56, 30, 12, 2};
        t = theta * (longint'(1) << 17);
        u = t + fpcu_pkg::QUARTER_PI_Q30;
        if (u >= 0) k = u / fpcu_pkg::HALF_PI_Q30;
        else k = -((-u + fpcu_pkg::HALF_PI_Q30 - 1) / fpcu_pkg::HALF_PI_Q30);
        r = t - k * fpcu_pkg::HALF_PI_Q30;
        x2 = mul_round(r, r, 30);
        ts = longint'(1) << 30;
        tc = longint'(1) << 30;
        for (int i = 0; i < 5; i++) ts = (longint'(1) << 30) - mul_round(x2, ts, 30) / sden[i];
        for (int i = 0; i < 6; i++) tc = (longint'(1) << 30) - mul_round(x2, tc, 30) / cden[i];
        s = mul_round(r, ts, 30);
        case (k[1:0])
            2'd0: begin sn = s;  cs = tc;  end
            2'd1: begin sn = tc; cs = -s;  end
            2'd2: begin sn = -s; cs = -tc; end
            default: begin sn = -tc; cs = s; end
        endcase
    endfunction

    function void tilt(longint theta);
        longint dx, dy, dz, rx, rz, s, c, nx, ny, nz;
        longint unsigned ua, ub, a, b, q, m1, m;
        int sh;
        dx = tgt_x - pos_x;
        dy = tgt_y;
        dz = tgt_z - pos_z;
        ua = magn(dx);
        ub = magn(dz);
        sh = (ua >= (64'd1 << 31) || ub >= (64'd1 << 31)) ? 1 : 0;
        a = ua >> sh;
        b = ub >> sh;
        q = a * a + b * b;
        if (q == 0) return;    // no horizontal axis: skip the tilt
        m1 = floor_sqrt(q);
        rx = longint'((a << 30) / m1);
        rz = longint'((b << 30) / m1);
        if (dx < 0) rx = -rx;
        if (dz < 0) rz = -rz;
        m = m1 << sh;
        sin_cos(theta, s, c);
        nx = mul_round(c, dx, 30) - mul_round(s, mul_round(dy, rx, 30), 30);
        ny = mul_round(c, dy, 30) + mul_round(s, longint'(m), 30);
        nz = mul_round(c, dz, 30) - mul_round(s, mul_round(dy, rz, 30), 30);
        tgt_x = clip32(pos_x + nx);
        tgt_y = clip32(ny);
        tgt_z = clip32(pos_z + nz);
    endfunction

    function void turn(longint theta);
        longint dx, dz, s, c;
        dx = tgt_x - pos_x;
        dz = tgt_z - pos_z;
        sin_cos(theta, s, c);
        tgt_x = clip32(pos_x + mul_round(c, dx, 30) + mul_round(s, dz, 30));
        tgt_z = clip32(pos_z + mul_round(c, dz, 30) - mul_round(s, dx, 30));
    endfunction

    function void shift(longint vx, longint vz, longint spd);
        longint ddx, ddz;
        ddx = mul_round(spd, vx, 13);
        ddz = mul_round(spd, vz, 13);
        pos_x = clip32(pos_x + ddx);
        pos_z = clip32(pos_z + ddz);
        tgt_x = clip32(tgt_x + ddx);
        tgt_z = clip32(tgt_z + ddz);
    endfunction

    function void note_request(logic [1:0] cmd, logic signed [15:0] yaw,
                               logic signed [15:0] pitch, logic signed [15:0] spd);
        longint dx, dz, last, sum;
        t_view v;
        dx = tgt_x - pos_x;
        dz = tgt_z - pos_z;
        case (cmd)
            2'd0: begin
                last = pitch_sum;
                sum = last + pitch;
                if (sum > pitch_lim) begin
                    pitch_sum = pitch_lim;
                    if (last != pitch_lim) tilt(pitch_lim - last);
                end else if (sum < -pitch_lim) begin
                    pitch_sum = -pitch_lim;
                    if (last != -pitch_lim) tilt(-pitch_lim - last);
                end else begin
                    pitch_sum = sum;
                    tilt(pitch);
                end
                turn(yaw);
            end
            2'd1: shift(dx, dz, spd);
            2'd2: shift(dz, -dx, spd);
            default: ;
        endcase
        v.px = pos_x;
        v.pz = pos_z;
        v.lx = tgt_x;
        v.ly = tgt_y;
        v.lz = tgt_z;
        v.pt = pitch_sum;
        expected_views.push_back(v);
    endfunction

    function void compare(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endfunction

    function void check_view(logic signed [31:0] px, logic signed [31:0] pz,
                             logic signed [31:0] lx, logic signed [31:0] ly,
                             logic signed [31:0] lz, logic signed [14:0] pt);
        t_view v;
        if (expected_views.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        v = expected_views.pop_front();
        views_checked++;
        compare("pos_x", v.px, px);
        compare("pos_z", v.pz, pz);
        compare("look_x", v.lx, lx);
        compare("look_y", v.ly, ly);
        compare("look_z", v.lz, lz);
        compare("pitch_total", v.pt, pt);
    endfunction

endclass

module tb_first_person_camera_update;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [13:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd = '0;
    logic signed [15:0] i_yaw_angle = '0;
    logic signed [15:0] i_pitch_angle = '0;
    logic signed [15:0] i_speed = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_z, o_look_x, o_look_y, o_look_z;
    logic signed [14:0] o_pitch_total;

    camera_state_model cam = new();
    int n_looks = 0;
    int n_moves = 0;
    int n_limits = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int stall_cnt = 0;

    first_person_camera_update u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_yaw_angle(i_yaw_angle),
        .i_pitch_angle(i_pitch_angle), .i_speed(i_speed),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pos_x(o_pos_x), .o_pos_z(o_pos_z), .o_look_x(o_look_x),
        .o_look_y(o_look_y), .o_look_z(o_look_z), .o_pitch_total(o_pitch_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("first_person_camera_update regression: fail");
        $finish;
    end

    // receiver: one long hold-off early on, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && cam.views_checked >= 60) begin
            hold_done <= 1'b1;
            hold_left <= 2000;
            i_out_stall <= 1'b1;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (stall_cnt % 7 < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            cam.check_view(o_pos_x, o_pos_z, o_look_x, o_look_y, o_look_z, o_pitch_total);
    end

    task automatic send(input logic [1:0] c, input logic signed [15:0] y,
                        input logic signed [15:0] p, input logic signed [15:0] s);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= c;
        i_yaw_angle <= y;
        i_pitch_angle <= p;
        i_speed <= s;
        do @(posedge i_clk); while (o_in_stall);
        cam.note_request(c, y, p, s);
        if (c == 2'd0) n_looks++;
        else if (c != 2'd3) n_moves++;
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // drain every outstanding request, then write the limit
    task automatic write_limit(input logic [13:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cam.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cam.set_limit(v);
        n_limits++;
    endtask

    task automatic random_request();
        logic [1:0] c;
        logic signed [15:0] y, p, s;
        int sel;
        sel = $urandom_range(0, 99);
        c = (sel < 40) ? 2'd0 : (sel < 67) ? 2'd1 : (sel < 94) ? 2'd2 : 2'd3;
        y = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4000)) - 16'sd2000
                                        : 16'($urandom);
        p = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4000)) - 16'sd2000
                                       : 16'($urandom);
        s = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 6000)) - 16'sd3000
                                         : 16'($urandom);
        send(c, y, p, s);
    endtask

    task automatic random_phase(input int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && left > 0; i++) begin
                random_request();
                left--;
            end
            pause(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30));
        end
    endtask

    initial begin
        logic [13:0] lims[4];
        lims = '{14'd12868, 14'd0, 14'd16383, 14'($urandom_range(0, 12868))};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, clamps, each command
        send(2'd0, 16'sd0, 16'sd0, 16'sd0);
        send(2'd0, 16'sd0, 16'sd32767, 16'sd0);
        send(2'd0, 16'sd0, 16'sd100, 16'sd0);           // already at limit
        send(2'd0, 16'sd32767, -16'sd32768, 16'sd0);
        send(2'd0, -16'sd32768, -16'sd5, 16'sd0);
        send(2'd0, 16'sd12868, 16'sd12288, 16'sd0);
        send(2'd1, 16'sd0, 16'sd0, 16'sd32767);
        send(2'd1, 16'sd0, 16'sd0, -16'sd32768);
        send(2'd1, 16'sd0, 16'sd0, 16'sd0);
        send(2'd2, 16'sd0, 16'sd0, 16'sd32767);
        send(2'd2, 16'sd0, 16'sd0, -16'sd32768);
        send(2'd3, -16'sd1, -16'sd1, -16'sd1);
        send(2'd0, -16'sd1, 16'sd1, 16'sd0);
        send(2'd2, 16'sd0, 16'sd0, 16'sd8192);
        pause(0);
        write_limit(14'd12288);
        send(2'd0, 16'sd0, -16'sd3000, 16'sd0);

        for (int ph = 0; ph < 4; ph++) begin
            write_limit(lims[ph]);    // limit zero also lowers a nonzero pitch sum
            random_phase(180);
        end
        write_limit(14'd12288);

        // end of run: a stretch of full-speed moves, then a few mixed requests
        for (int i = 0; i < 60; i++)
            send(($urandom_range(0, 3) == 0) ? 2'd2 : 2'd1, 16'sd0, 16'sd0, -16'sd32768);
        for (int i = 0; i < 20; i++) random_request();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cam.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d looks, %0d moves, %0d limit writes; %0d results checked",
                 n_looks, n_moves, n_limits, cam.views_checked);
        $display("including clamps, lowered limits, long receiver hold-off, full-speed moves");
        if (cam.errors == 0 && cam.pending() == 0) begin
            $display("first_person_camera_update regression: pass");
        end else begin
            $display("first_person_camera_update regression: fail");
        end
        $finish;
    end

endmodule
